// File: rtl/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Types, constants and message tables shared by the line editor modules.
// ----------------------------------------------------------------------------
package sle_pkg;

  // line store depth and derived widths
  localparam int unsigned Depth  = 32;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned MaxRes = 48;
  localparam int unsigned CntW   = $clog2(MaxRes);

  // special characters
  localparam logic [7:0] ChCr  = 8'h0D;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChBs  = 8'h08;
  localparam logic [7:0] ChDel = 8'h7F;

  localparam logic ModeByte = 1'b0;
  localparam logic ModeAck  = 1'b1;

  // echo messages
  localparam int unsigned TypedLen  = 13;
  localparam int unsigned PromptLen = 4;
  localparam int unsigned EraseLen  = 3;

  localparam logic [7:0] TypedMsg [TypedLen] = '{
    8'h0D, 8'h0A, 8'h59, 8'h6F, 8'h75, 8'h20, 8'h74,
    8'h79, 8'h70, 8'h65, 8'h64, 8'h3A, 8'h20
  };
  localparam logic [7:0] PromptMsg [PromptLen] = '{8'h0D, 8'h0A, 8'h3E, 8'h20};
  localparam logic [7:0] EraseMsg [EraseLen] = '{8'h08, 8'h20, 8'h08};

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;
    logic       line_pending;
  } out_item_t;

  // controller to line store
  typedef struct packed {
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic [AddrW-1:0] rd_addr;
  } ram_req_t;

  typedef enum logic [2:0] {
    StIdle,
    StSingle,
    StErase,
    StTyped,
    StLine,
    StPrompt
  } state_e;

endpackage

// File: rtl/sle_line_ram.sv
// ----------------------------------------------------------------------------
// sle_line_ram
// Line store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sle_line_ram (
  input  logic              clk_i,
  input  sle_pkg::ram_req_t req_i,
  output logic [7:0]        rdata_o
);
  import sle_pkg::*;

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    rdata_q <= mem_q[req_i.rd_addr];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/sle_ctrl.sv
// ----------------------------------------------------------------------------
// sle_ctrl
// Line editor sequencer: decodes each input, updates count and pending
// flag, and walks the echo sequence into the output register.
// ----------------------------------------------------------------------------
module sle_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sle_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sle_pkg::out_item_t  out_item_o,
  output sle_pkg::ram_req_t   ram_req_o,
  input  logic [7:0]          ram_rdata_i
);
  import sle_pkg::*;

  state_e           state_q, state_d;
  logic [3:0]       msg_idx_q, msg_idx_d;
  logic [AddrW-1:0] line_idx_q, line_idx_d;
  logic [AddrW-1:0] line_len_q, line_len_d;
  logic [AddrW-1:0] fill_q, fill_d;
  logic             pend_q, pend_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             single_vld_q, single_vld_d;
  logic [7:0]       byte_q, byte_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q;

  logic       in_take;
  logic       slot_free;
  logic       emit_valid;
  logic       emit_last;
  logic       last_nat;
  logic       emit_tx_vld;
  logic [7:0] emit_byte;
  logic       take;
  logic       line_done;

  assign in_ready_o = (state_q == StIdle);
  assign in_take    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign line_done  = (line_idx_q == line_len_q) || (ram_rdata_i == 8'h00);

  // item generation per state
  always_comb begin
    emit_valid  = 1'b0;
    emit_tx_vld = 1'b1;
    emit_byte   = 8'h00;
    last_nat    = 1'b0;
    unique case (state_q)
      StIdle: begin
        emit_valid = 1'b0;
      end
      StSingle: begin
        emit_valid  = 1'b1;
        emit_tx_vld = single_vld_q;
        emit_byte   = single_vld_q ? byte_q : 8'h00;
        last_nat    = 1'b1;
      end
      StErase: begin
        emit_valid = 1'b1;
        emit_byte  = EraseMsg[msg_idx_q[1:0]];
        last_nat   = (msg_idx_q == 4'(EraseLen - 1));
      end
      StTyped: begin
        emit_valid = 1'b1;
        emit_byte  = TypedMsg[msg_idx_q];
      end
      StLine: begin
        emit_valid = !line_done;
        emit_byte  = ram_rdata_i;
      end
      StPrompt: begin
        emit_valid = 1'b1;
        emit_byte  = PromptMsg[msg_idx_q[1:0]];
        last_nat   = (msg_idx_q == 4'(PromptLen - 1));
      end
      default: begin
        emit_valid = 1'b0;
      end
    endcase
  end

  // the result count caps one input's echo
  assign emit_last = last_nat || (cnt_q == CntW'(MaxRes - 1));
  assign take      = emit_valid && slot_free;

  // next state and state registers
  always_comb begin
    state_d      = state_q;
    msg_idx_d    = msg_idx_q;
    line_idx_d   = line_idx_q;
    line_len_d   = line_len_q;
    fill_d       = fill_q;
    pend_d       = pend_q;
    cnt_d        = cnt_q;
    single_vld_d = single_vld_q;
    byte_d       = byte_q;
    ram_req_o    = '0;

    priority case (state_q)
      StIdle: begin
        if (in_take) begin
          msg_idx_d = '0;
          cnt_d     = '0;
          byte_d    = in_item_i.rx_byte;
          if (in_item_i.mode == ModeAck) begin
            pend_d       = 1'b0;
            single_vld_d = 1'b0;
            state_d      = StSingle;
          end else if (in_item_i.rx_byte == ChCr || in_item_i.rx_byte == ChLf) begin
            if (fill_q != '0) begin
              pend_d     = 1'b1;
              line_idx_d = '0;
              line_len_d = fill_q;
              fill_d     = '0;
              state_d    = StTyped;
            end else begin
              state_d = StPrompt;
            end
          end else if (in_item_i.rx_byte == ChBs || in_item_i.rx_byte == ChDel) begin
            if (fill_q != '0) begin
              fill_d  = fill_q - AddrW'(1);
              state_d = StErase;
            end else begin
              single_vld_d = 1'b0;
              state_d      = StSingle;
            end
          end else begin
            if (fill_q < AddrW'(Depth - 1)) begin
              ram_req_o.wr_en   = 1'b1;
              ram_req_o.wr_addr = fill_q;
              ram_req_o.wr_data = in_item_i.rx_byte;
              fill_d            = fill_q + AddrW'(1);
              single_vld_d      = 1'b1;
            end else begin
              single_vld_d = 1'b0;
            end
            state_d = StSingle;
          end
        end
      end
      StLine: begin
        if (line_done) begin
          msg_idx_d = '0;
          state_d   = StPrompt;
        end else if (take) begin
          cnt_d      = cnt_q + CntW'(1);
          line_idx_d = line_idx_q + AddrW'(1);
          if (emit_last) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        if (take) begin
          cnt_d     = cnt_q + CntW'(1);
          msg_idx_d = msg_idx_q + 4'd1;
          if (emit_last) begin
            state_d = StIdle;
          end else if (state_q == StTyped && msg_idx_q == 4'(TypedLen - 1)) begin
            state_d = StLine;
          end
        end
      end
    endcase

    // read one ahead so the data for line_idx_q is there in the next cycle
    ram_req_o.rd_addr = line_idx_d;
  end

  assign out_valid_d = take ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      msg_idx_q    <= '0;
      line_idx_q   <= '0;
      line_len_q   <= '0;
      fill_q       <= '0;
      pend_q       <= 1'b0;
      cnt_q        <= '0;
      single_vld_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      msg_idx_q    <= msg_idx_d;
      line_idx_q   <= line_idx_d;
      line_len_q   <= line_len_d;
      fill_q       <= fill_d;
      pend_q       <= pend_d;
      cnt_q        <= cnt_d;
      single_vld_q <= single_vld_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    if (take) begin
      out_q.tx_valid     <= emit_tx_vld;
      out_q.tx_byte      <= emit_byte;
      out_q.last         <= emit_last;
      out_q.line_pending <= pend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: rtl/serial_line_editor_echo_top.sv
// ----------------------------------------------------------------------------
// serial_line_editor_echo_top
// Serial terminal line editor: gathers received bytes into a line and
// produces the echo stream, one transfer per echo byte.
// ----------------------------------------------------------------------------
// Input channel: one transfer per received byte (mode 0) or per line
// acknowledge (mode 1). Output channel: the echo bytes for that input, the
// final one marked with last; an input with nothing to echo gives a single
// transfer with tx_valid low. line_pending carries the flag after the input.
// The input transfer is latched into the sequencer state, and the first
// result is then registered in the output register. Inputs are taken one
// at a time; the next is accepted once the last result of the previous one
// has entered the output register. The sequencer emits one byte per cycle
// from the message tables and the line store read port, while the output
// register is free to take it.
// Reset clears the fill count and pending flag; the line store needs no
// clearing since only written entries are read.
// A stalled receiver holds the output register and the sequencer waits,
// so no result is lost.
module serial_line_editor_echo_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sle_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sle_pkg::out_item_t  out_item_o
);
  import sle_pkg::*;

  ram_req_t   ram_req;
  logic [7:0] ram_rdata;

  sle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  sle_line_ram u_line_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

endmodule
